/* rtl/core/ftws_pkg.sv */
// Shared types and constants for the frame-time window statistics unit.
// No dependencies.
`default_nettype none

package ftws_pkg;

  localparam int TS_W       = 32;  // timestamp and sample width
  localparam int SUM_W      = 37;  // reported window sum width
  localparam int RING_DEPTH = 32;  // sample ring entries
  localparam int RING_AW    = 5;   // ring address width

  // Control from the sequencer to the accumulator.
  typedef struct packed {
    logic clr;  // start a new walk
    logic add;  // fold one ring sample into sum/min/max
  } acc_ctrl_t;

endpackage

`default_nettype wire

/* rtl/core/ftws_acc.sv */
// Sum / min / max accumulator for the ring walk.
// Depends on ftws_pkg.
`default_nettype none

module ftws_acc #(
  parameter int WINDOW = 32
) (
  input  wire logic                        clk,
  input  wire ftws_pkg::acc_ctrl_t         ctrl,
  input  wire logic [ftws_pkg::TS_W-1:0]   sample,
  output logic      [ftws_pkg::SUM_W-1:0]  sum,
  output logic      [ftws_pkg::TS_W-1:0]   min_val,
  output logic      [ftws_pkg::TS_W-1:0]   max_val
);
  import ftws_pkg::*;

  // Worst case is WINDOW full-scale samples; keep at least one guard bit above SUM_W.
  localparam int RAW_W = TS_W + $clog2(WINDOW);
  localparam int ACC_W = (RAW_W > SUM_W) ? RAW_W : SUM_W + 1;

  logic [ACC_W-1:0] acc_r;
  logic [TS_W-1:0]  min_r;
  logic [TS_W-1:0]  max_r;

  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      acc_r <= '0;
      min_r <= '1;
      max_r <= '0;
    end else if (ctrl.add) begin
      acc_r <= acc_r + ACC_W'(sample);
      if (sample < min_r) min_r <= sample;
      if (sample > max_r) max_r <= sample;
    end
  end

  // Saturate at the top of the reported width.
  assign sum     = (|acc_r[ACC_W-1:SUM_W]) ? {SUM_W{1'b1}} : acc_r[SUM_W-1:0];
  assign min_val = min_r;
  assign max_val = max_r;

endmodule

`default_nettype wire

/* rtl/core/frame_time_window_stats_unit.sv */
// Top level of the frame-time window statistics unit: ring memory, walk sequencer
// and output register. Depends on ftws_pkg and ftws_acc.
`default_nettype none

// Channel  | Ports          | Payload (low bit first)
// ---------+----------------+---------------------------------------------------
// input    | in_t*  (slave) | timestamp_ms[31:0]
// result   | out_t* (master)| frame_time[31:0], window_sum[68:32],
//          |                | window_min[100:69], window_max[132:101], pad
//
// Sequence: an accepted item is walked through fill reads of the ring, newest first, where fill
//   is the number of samples read (min of samples taken and WINDOW), then S_DRAIN and S_DONE;
//   the result is loaded in S_DONE, and the next item is taken only back in S_IDLE. The single
//   read port of the ring, one sample a cycle, paces the walk.
// Reset: synchronous, active low; clears the position, fill count, last timestamp
//   and control. Ring contents are not cleared; unwritten entries are never read.
// Stalls: a result waits in the output register while the next item is accepted
//   and walked; the walk holds at its end only if that register is still full.

module frame_time_window_stats_unit #(
  parameter int WINDOW = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [31:0]  in_tdata,   // timestamp_ms[31:0]
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic      [135:0] out_tdata   // frame_time, window_sum, window_min, window_max
);
  import ftws_pkg::*;

  localparam int FILL_W = $clog2(WINDOW + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t              state_r;
  logic [RING_AW-1:0]  wp_r;       // slot of the next write
  logic [FILL_W-1:0]   fill_r;     // samples taken, saturating at WINDOW
  logic [FILL_W-1:0]   fill_nxt;
  logic [FILL_W-1:0]   cnt_r;      // reads left in this walk
  logic [RING_AW-1:0]  rd_addr_r;
  logic                rd_vld_r;   // rdata_r holds a sample this cycle
  logic [TS_W-1:0]     rdata_r;
  logic [TS_W-1:0]     last_ts_r;
  logic [TS_W-1:0]     ft_r;
  logic [TS_W-1:0]     ft_nxt;
  logic                in_acc;
  logic                out_free;
  acc_ctrl_t           acc_ctrl;
  logic [SUM_W-1:0]    acc_sum;
  logic [TS_W-1:0]     acc_min;
  logic [TS_W-1:0]     acc_max;

  logic [TS_W-1:0]     ring_mem [RING_DEPTH];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid || out_tready;
  assign ft_nxt    = in_tdata - last_ts_r;
  assign fill_nxt  = (fill_r == FILL_W'(WINDOW)) ? fill_r : fill_r + 1'b1;

  // Ring: new sample written at acceptance, walk reads start the next cycle.
  always_ff @(posedge clk) begin
    if (in_acc) ring_mem[wp_r] <= ft_nxt;
    rdata_r <= ring_mem[rd_addr_r];
  end

  assign acc_ctrl.clr = in_acc;
  assign acc_ctrl.add = rd_vld_r;

  ftws_acc #(
    .WINDOW (WINDOW)
  ) u_acc (
    .clk     (clk),
    .ctrl    (acc_ctrl),
    .sample  (rdata_r),
    .sum     (acc_sum),
    .min_val (acc_min),
    .max_val (acc_max)
  );

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      wp_r       <= '0;
      fill_r     <= '0;
      last_ts_r  <= '0;
      rd_vld_r   <= 1'b0;
      out_tvalid <= 1'b0;
    end else begin
      rd_vld_r <= (state_r == S_WALK);
      // S_DONE reloads the register itself
      if (out_tvalid && out_tready && (state_r != S_DONE)) out_tvalid <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            last_ts_r <= in_tdata;
            ft_r      <= ft_nxt;
            fill_r    <= fill_nxt;
            cnt_r     <= fill_nxt;
            rd_addr_r <= wp_r;        // newest first
            wp_r      <= wp_r + 1'b1;
            state_r   <= S_WALK;
          end
        end
        S_WALK: begin
          rd_addr_r <= rd_addr_r - 1'b1;
          cnt_r     <= cnt_r - 1'b1;
          if (cnt_r == FILL_W'(1)) state_r <= S_DRAIN;
        end
        S_DRAIN: begin
          state_r <= S_DONE;        // last sample folds in at this edge
        end
        S_DONE: begin
          if (out_free) begin
            out_tvalid <= 1'b1;
            out_tdata  <= {3'b000, acc_max, acc_min, acc_sum, ft_r};
            state_r    <= S_IDLE;
          end else if (out_tvalid && out_tready) begin
            out_tvalid <= 1'b0;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Fill count never passes the window length.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(WINDOW))
    else $error("fill count above window");

  // Each accepted item advances the write slot by exactly one.
  a_wp_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (wp_r == $past(wp_r) + 1'b1))
    else $error("write slot did not advance");

  // A walk always starts with a nonzero read count equal to the new fill.
  a_walk_len: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_WALK) && (cnt_r == fill_r) && (cnt_r != '0))
    else $error("bad walk length");

  // Read data is folded in only in the cycle after a walk read.
  a_rd_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> $past(state_r == S_WALK))
    else $error("stray read valid");

endmodule

`default_nettype wire
